### hw/rtl/ccc_pkg.sv
// Package for the calorimeter cluster centroid block: sizes, codes, command types.
// Used by every module under hw/rtl except ccc_ram; depends on nothing.
`default_nettype none

package ccc_pkg;

    localparam int GRID_COLS = 40;
    localparam int GRID_ROWS = 40;
    localparam int MAX_HITS  = 64;

    localparam int ADDR_W  = $clog2(MAX_HITS);
    localparam int CNT_W   = $clog2(MAX_HITS + 1);
    localparam int POS_W   = 6;
    localparam int E_W     = 24;
    localparam int HIT_W   = 2 * POS_W + E_W;
    localparam int ESUM_W  = 30;
    localparam int ELOC_W  = 28;
    localparam int LCNT_W  = 4;
    localparam int TERM_W  = POS_W + 3;
    localparam int PROD_W  = E_W + 1 + TERM_W;
    localparam int SX_W    = PROD_W + 4;
    localparam int SX2_W   = SX_W + 11;
    localparam int NUM_W   = SX2_W + 1;
    localparam int DEN_W   = ELOC_W + 1;
    localparam int Q_W     = 17;
    localparam int DSH_W   = DEN_W + Q_W - 1;
    localparam int CRD_W   = 36;
    localparam int Z_W     = 26;
    localparam int SQI_W   = 32;
    localparam int SQ_W    = 60;
    localparam int STEP_W  = 5;
    localparam int PADDR_W = 4;

    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(Q_W - 1);
    localparam logic [STEP_W-1:0] CORD_LAST = STEP_W'(15);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(29);

    localparam logic [ESUM_W-1:0]       ESUM_MAX = '1;
    localparam logic signed [Z_W-1:0]   DEG180   = Z_W'(180 * 32768);
    localparam logic signed [Z_W-1:0]   PHI_MAX  = Z_W'(23040);
    localparam logic signed [Z_W-1:0]   PHI_MIN  = -Z_W'(23040);
    localparam logic signed [Z_W-1:0]   TH_MAX   = Z_W'(11520);
    localparam logic [15:0]             DEPTH_OFS = 16'd80;

    localparam logic [1:0] REG_PITCH_X    = 2'd0;
    localparam logic [1:0] REG_PITCH_Y    = 2'd1;
    localparam logic [1:0] REG_FRONT_DIST = 2'd2;

    localparam logic SEL_X = 1'b0;
    localparam logic SEL_Y = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_MUL,
        S_DIVX_INIT, S_DIVX, S_DIVX_ST,
        S_DIVY_INIT, S_DIVY, S_DIVY_ST,
        S_SQR, S_SQRT_INIT, S_SQRT,
        S_PHI_INIT, S_PHI, S_PHI_ST,
        S_TH_INIT, S_TH, S_TH_ST,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_SCAN, OP_MUL,
        OP_DIV_INIT, OP_DIV_STEP, OP_DIV_STORE,
        OP_SQR, OP_SQRT_INIT, OP_SQRT_STEP,
        OP_CORD_INIT, OP_CORD_STEP, OP_CORD_STORE,
        OP_DONE
    } op_t;

    typedef struct packed {
        logic               load;
        op_t                op;
        logic               sel;
        logic [STEP_W-1:0]  step;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic degen;
    } status_t;

    typedef struct packed {
        logic [9:0]  pitch_x;
        logic [9:0]  pitch_y;
        logic [15:0] front_distance;
    } cfg_t;

    function automatic logic signed [Z_W-1:0] atan_lut(input logic [3:0] k);
        logic signed [Z_W-1:0] a;
        case (k)
            4'd0:    a = Z_W'(1474560);
            4'd1:    a = Z_W'(870484);
            4'd2:    a = Z_W'(459940);
            4'd3:    a = Z_W'(233473);
            4'd4:    a = Z_W'(117189);
            4'd5:    a = Z_W'(58652);
            4'd6:    a = Z_W'(29333);
            4'd7:    a = Z_W'(14667);
            4'd8:    a = Z_W'(7334);
            4'd9:    a = Z_W'(3667);
            4'd10:   a = Z_W'(1833);
            4'd11:   a = Z_W'(917);
            4'd12:   a = Z_W'(458);
            4'd13:   a = Z_W'(229);
            4'd14:   a = Z_W'(115);
            default: a = Z_W'(57);
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ccc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module ccc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/ccc_regs.sv
// APB-style configuration registers: pitches and front face distance.
// Depends on ccc_pkg.
`default_nettype none

module ccc_regs import ccc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [9:0]  pitch_x_reg;
    logic [9:0]  pitch_y_reg;
    logic [15:0] front_dist_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_x_reg    <= 10'd240;
            pitch_y_reg    <= 10'd240;
            front_dist_reg <= 16'd7360;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_PITCH_X:    pitch_x_reg    <= pwdata[9:0];
                REG_PITCH_Y:    pitch_y_reg    <= pwdata[9:0];
                REG_FRONT_DIST: front_dist_reg <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_PITCH_X:    prdata = {22'd0, pitch_x_reg};
            REG_PITCH_Y:    prdata = {22'd0, pitch_y_reg};
            REG_FRONT_DIST: prdata = {16'd0, front_dist_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg = '{pitch_x: pitch_x_reg, pitch_y: pitch_y_reg,
                   front_distance: front_dist_reg};

endmodule

`default_nettype wire

### hw/rtl/ccc_datapath.sv
// Datapath: hit store, peak tracking, 3x3 scan, divider, square root, CORDIC.
// Depends on ccc_pkg and ccc_ram.
`default_nettype none

module ccc_datapath import ccc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    input  cfg_t                     cfg,
    input  logic [POS_W-1:0]         col,
    input  logic [POS_W-1:0]         row,
    input  logic [E_W-1:0]           energy,
    output status_t                  status,
    output logic [ESUM_W-1:0]        total_energy,
    output logic [CNT_W-1:0]         hit_count,
    output logic                     overflow,
    output logic [POS_W-1:0]         max_col,
    output logic [POS_W-1:0]         max_row,
    output logic [ELOC_W-1:0]        local_energy,
    output logic [LCNT_W-1:0]        local_count,
    output logic signed [15:0]       x_centroid,
    output logic signed [15:0]       y_centroid,
    output logic signed [15:0]       phi,
    output logic [13:0]              theta,
    output logic                     degenerate
);

    // event state
    logic [CNT_W-1:0]   count_reg;
    logic [ESUM_W-1:0]  esum_reg;
    logic               drop_reg;
    logic [E_W-1:0]     pk_e_reg;
    logic [POS_W-1:0]   pk_col_reg;
    logic [POS_W-1:0]   pk_row_reg;

    // scan
    logic [ADDR_W-1:0]  scan_addr_reg;
    logic               vld_reg;
    logic [8:0]         found_reg;
    logic [ELOC_W-1:0]  eloc_reg;
    logic [LCNT_W-1:0]  lcnt_reg;
    logic signed [SX_W-1:0]  sx_reg;
    logic signed [SX_W-1:0]  sy_reg;
    logic signed [SX2_W-1:0] sx2_reg;
    logic signed [SX2_W-1:0] sy2_reg;

    // divider
    logic [NUM_W-1:0]   rem_reg;
    logic [DSH_W-1:0]   dsh_reg;
    logic [Q_W-1:0]     q_reg;
    logic               sat_reg;
    logic               neg_reg;
    logic signed [15:0] xc_reg;
    logic signed [15:0] yc_reg;

    // square root
    logic [SQI_W-1:0]   sq_reg;
    logic [SQ_W-1:0]    v_reg;
    logic [SQ_W-1:0]    res_reg;
    logic [SQ_W-1:0]    bit_reg;

    // CORDIC
    logic signed [CRD_W-1:0] cx_reg;
    logic signed [CRD_W-1:0] cy_reg;
    logic signed [Z_W-1:0]   cz_reg;
    logic signed [15:0]      phi_reg;
    logic [13:0]             theta_reg;

    logic                    load_ok;
    logic                    we;
    logic [ESUM_W:0]         esum_add;
    logic [ESUM_W-1:0]       esum_next;
    logic [HIT_W-1:0]        rdata;
    logic [POS_W-1:0]        h_col;
    logic [POS_W-1:0]        h_row;
    logic [E_W-1:0]          h_e;
    logic signed [POS_W:0]   dc;
    logic signed [POS_W:0]   dr;
    logic                    hit_in;
    logic [1:0]              ci;
    logic [1:0]              ri;
    logic [3:0]              nb_sel;
    logic signed [TERM_W-1:0] tx;
    logic signed [TERM_W-1:0] ty;
    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] py;
    logic                    take;
    logic signed [SX2_W-1:0] num_s;
    logic [SX2_W-1:0]        num_mag;
    logic [NUM_W-1:0]        num_tot;
    logic [DEN_W-1:0]        den;
    logic [Q_W-1:0]          qc;
    logic signed [15:0]      cres;
    logic [SQ_W-1:0]         trial;
    logic signed [17:0]      depth;
    logic signed [CRD_W-1:0] xs;
    logic signed [CRD_W-1:0] ys;
    logic signed [CRD_W-1:0] cdx;
    logic signed [CRD_W-1:0] cdy;
    logic [3:0]              k;
    logic signed [Z_W-1:0]   zu;
    logic [CNT_W-1:0]        scan_cnt;

    assign load_ok   = count_reg < CNT_W'(MAX_HITS);
    assign we        = cmd.load && load_ok;
    assign esum_add  = {1'b0, esum_reg} + (ESUM_W+1)'(energy);
    assign esum_next = (esum_add > {1'b0, ESUM_MAX}) ? ESUM_MAX : esum_add[ESUM_W-1:0];

    ccc_ram #(
        .WIDTH (HIT_W),
        .DEPTH (MAX_HITS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({col, row, energy}),
        .raddr (scan_addr_reg),
        .rdata (rdata)
    );

    assign {h_col, h_row, h_e} = rdata;
    assign dc     = $signed({1'b0, h_col}) - $signed({1'b0, pk_col_reg});
    assign dr     = $signed({1'b0, h_row}) - $signed({1'b0, pk_row_reg});
    assign hit_in = (dc >= -1) && (dc <= 1) && (dr >= -1) && (dr <= 1);
    assign ci     = dc[1:0] + 2'd1;
    assign ri     = dr[1:0] + 2'd1;
    assign nb_sel = {2'd0, ci} * 4'd3 + {2'd0, ri};
    assign tx     = $signed({2'd0, h_col, 1'b0}) - TERM_W'(GRID_COLS - 1);
    assign ty     = $signed({2'd0, h_row, 1'b0}) - TERM_W'(GRID_ROWS - 1);
    assign px     = $signed({1'b0, h_e}) * tx;
    assign py     = $signed({1'b0, h_e}) * ty;
    assign take   = vld_reg && hit_in && !found_reg[nb_sel];

    assign scan_cnt         = CNT_W'(scan_addr_reg) + CNT_W'(1);
    assign status.scan_last = (scan_cnt == count_reg);
    assign status.degen     = (eloc_reg == '0) || (cfg.front_distance <= DEPTH_OFS);

    assign num_s   = (cmd.sel == SEL_Y) ? sy2_reg : sx2_reg;
    assign num_mag = num_s[SX2_W-1] ? SX2_W'(-num_s) : SX2_W'(num_s);
    assign num_tot = NUM_W'(num_mag) + NUM_W'(eloc_reg);
    assign den     = {eloc_reg, 1'b0};

    assign qc   = (sat_reg || q_reg > Q_W'(32768)) ? Q_W'(32768) : q_reg;
    assign cres = neg_reg ? 16'(Q_W'(0) - qc)
                          : ((qc > Q_W'(32767)) ? 16'sh7FFF : qc[15:0]);

    assign trial = res_reg + bit_reg;
    assign depth = $signed({2'b00, cfg.front_distance}) - 18'sd80;
    assign xs    = CRD_W'(xc_reg) <<< 14;
    assign ys    = CRD_W'(yc_reg) <<< 14;
    assign k     = cmd.step[3:0];
    assign cdx   = cy_reg >>> k;
    assign cdy   = cx_reg >>> k;
    assign zu    = (cz_reg + Z_W'(128)) >>> 8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            esum_reg      <= '0;
            drop_reg      <= 1'b0;
            scan_addr_reg <= '0;
            vld_reg       <= 1'b0;
            found_reg     <= '0;
        end
        else
        begin
            vld_reg <= (cmd.op == OP_SCAN);
            if (cmd.load)
            begin
                scan_addr_reg <= '0;
                found_reg     <= '0;
                if (load_ok)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    esum_reg  <= esum_next;
                end
                else
                begin
                    drop_reg <= 1'b1;
                end
            end
            else if (cmd.op == OP_DONE)
            begin
                count_reg <= '0;
                esum_reg  <= '0;
                drop_reg  <= 1'b0;
            end
            if (cmd.op == OP_SCAN)
            begin
                scan_addr_reg <= scan_addr_reg + ADDR_W'(1);
            end
            if (take)
            begin
                found_reg[nb_sel] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (count_reg == '0 || pk_e_reg < energy))
        begin
            pk_e_reg   <= energy;
            pk_col_reg <= col;
            pk_row_reg <= row;
        end
        if (cmd.load)
        begin
            eloc_reg <= '0;
            lcnt_reg <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
        end
        else if (take)
        begin
            eloc_reg <= eloc_reg + ELOC_W'(h_e);
            lcnt_reg <= lcnt_reg + LCNT_W'(1);
            sx_reg   <= sx_reg + SX_W'(px);
            sy_reg   <= sy_reg + SX_W'(py);
        end

        case (cmd.op)
            OP_MUL:
            begin
                sx2_reg <= $signed({1'b0, cfg.pitch_x}) * sx_reg;
                sy2_reg <= $signed({1'b0, cfg.pitch_y}) * sy_reg;
            end
            OP_DIV_INIT:
            begin
                rem_reg <= num_tot;
                dsh_reg <= {den, {(Q_W-1){1'b0}}};
                q_reg   <= '0;
                sat_reg <= num_tot >= NUM_W'({den, {Q_W{1'b0}}});
                neg_reg <= num_s[SX2_W-1];
            end
            OP_DIV_STEP:
            begin
                if (rem_reg >= NUM_W'(dsh_reg))
                begin
                    rem_reg <= rem_reg - NUM_W'(dsh_reg);
                    q_reg   <= {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[Q_W-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
            end
            OP_DIV_STORE:
            begin
                if (cmd.sel == SEL_Y)
                begin
                    yc_reg <= cres;
                end
                else
                begin
                    xc_reg <= cres;
                end
            end
            OP_SQR:
            begin
                sq_reg <= SQI_W'(SQI_W'(xc_reg) * SQI_W'(xc_reg))
                        + SQI_W'(SQI_W'(yc_reg) * SQI_W'(yc_reg));
            end
            OP_SQRT_INIT:
            begin
                v_reg   <= {sq_reg, {(SQ_W-SQI_W){1'b0}}};
                res_reg <= '0;
                bit_reg <= SQ_W'(1) << (SQ_W - 2);
            end
            OP_SQRT_STEP:
            begin
                if (v_reg >= trial)
                begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_CORD_INIT:
            begin
                if (cmd.sel == SEL_Y)
                begin
                    cx_reg <= CRD_W'(depth) <<< 14;
                    cy_reg <= CRD_W'(res_reg);
                    cz_reg <= '0;
                end
                else if (xc_reg < 0)
                begin
                    cx_reg <= -xs;
                    cy_reg <= -ys;
                    cz_reg <= (yc_reg >= 0) ? DEG180 : -DEG180;
                end
                else
                begin
                    cx_reg <= xs;
                    cy_reg <= ys;
                    cz_reg <= '0;
                end
            end
            OP_CORD_STEP:
            begin
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + cdx;
                    cy_reg <= cy_reg - cdy;
                    cz_reg <= cz_reg + atan_lut(k);
                end
                else if (cy_reg < 0)
                begin
                    cx_reg <= cx_reg - cdx;
                    cy_reg <= cy_reg + cdy;
                    cz_reg <= cz_reg - atan_lut(k);
                end
            end
            OP_CORD_STORE:
            begin
                if (cmd.sel == SEL_Y)
                begin
                    theta_reg <= (zu < 0) ? 14'd0 : ((zu > TH_MAX) ? 14'(TH_MAX) : zu[13:0]);
                end
                else
                begin
                    phi_reg <= (zu > PHI_MAX) ? 16'(PHI_MAX)
                             : ((zu < PHI_MIN) ? 16'(PHI_MIN) : zu[15:0]);
                end
            end
            OP_DONE:
            begin
                total_energy <= esum_reg;
                hit_count    <= count_reg;
                overflow     <= drop_reg;
                max_col      <= pk_col_reg;
                max_row      <= pk_row_reg;
                local_energy <= eloc_reg;
                local_count  <= lcnt_reg;
                degenerate   <= status.degen;
                x_centroid   <= status.degen ? 16'sd0 : xc_reg;
                y_centroid   <= status.degen ? 16'sd0 : yc_reg;
                phi          <= status.degen ? 16'sd0 : phi_reg;
                theta        <= status.degen ? 14'd0 : theta_reg;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/ccc_ctrl.sv
// Controller: sequences hit loading, the 3x3 scan and the centroid arithmetic.
// Depends on ccc_pkg.
`default_nettype none

module ccc_ctrl import ccc_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    last,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic              done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= (state_reg == S_DONE);
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        cmd.load   = 1'b0;
        cmd.op     = OP_NOP;
        cmd.sel    = SEL_X;
        cmd.step   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start && last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (status.degen)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_MUL;
                    state_next = S_DIVX_INIT;
                end
            end
            S_DIVX_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                state_next = S_DIVX;
            end
            S_DIVX:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DIVX_ST;
                end
            end
            S_DIVX_ST:
            begin
                cmd.op     = OP_DIV_STORE;
                state_next = S_DIVY_INIT;
            end
            S_DIVY_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                cmd.sel    = SEL_Y;
                state_next = S_DIVY;
            end
            S_DIVY:
            begin
                cmd.op   = OP_DIV_STEP;
                cmd.sel  = SEL_Y;
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DIVY_ST;
                end
            end
            S_DIVY_ST:
            begin
                cmd.op     = OP_DIV_STORE;
                cmd.sel    = SEL_Y;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                cmd.op     = OP_SQR;
                state_next = S_SQRT_INIT;
            end
            S_SQRT_INIT:
            begin
                cmd.op     = OP_SQRT_INIT;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_PHI_INIT;
                end
            end
            S_PHI_INIT:
            begin
                cmd.op     = OP_CORD_INIT;
                state_next = S_PHI;
            end
            S_PHI:
            begin
                cmd.op   = OP_CORD_STEP;
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == CORD_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_PHI_ST;
                end
            end
            S_PHI_ST:
            begin
                cmd.op     = OP_CORD_STORE;
                state_next = S_TH_INIT;
            end
            S_TH_INIT:
            begin
                cmd.op     = OP_CORD_INIT;
                cmd.sel    = SEL_Y;
                state_next = S_TH;
            end
            S_TH:
            begin
                cmd.op   = OP_CORD_STEP;
                cmd.sel  = SEL_Y;
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == CORD_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_TH_ST;
                end
            end
            S_TH_ST:
            begin
                cmd.op     = OP_CORD_STORE;
                cmd.sel    = SEL_Y;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.op     = OP_DONE;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/calorimeter_cluster_centroid.sv
// Calorimeter 3x3 cluster centroid: top level joining registers, controller, datapath.
// Hits load one per cycle while idle; after the final hit, the result strobe
// follows the scan of the hit RAM, the 17-step divider run twice, the 30-step
// square root and the 16-step CORDIC run twice (only the scan for a degenerate
// event). busy stays high until the result is out.
// Reset clears event state and loads the register defaults; the receiver cannot stall.
`default_nettype none

module calorimeter_cluster_centroid import ccc_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [POS_W-1:0]    col,
    input  logic [POS_W-1:0]    row,
    input  logic [E_W-1:0]      energy,
    input  logic                last,
    output logic                done,
    output logic [ESUM_W-1:0]   total_energy,
    output logic [CNT_W-1:0]    hit_count,
    output logic                overflow,
    output logic [POS_W-1:0]    max_col,
    output logic [POS_W-1:0]    max_row,
    output logic [ELOC_W-1:0]   local_energy,
    output logic [LCNT_W-1:0]   local_count,
    output logic signed [15:0]  x_centroid,
    output logic signed [15:0]  y_centroid,
    output logic signed [15:0]  phi,
    output logic [13:0]         theta,
    output logic                degenerate,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    ccc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ccc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .last   (last),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    ccc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg),
        .col          (col),
        .row          (row),
        .energy       (energy),
        .status       (status),
        .total_energy (total_energy),
        .hit_count    (hit_count),
        .overflow     (overflow),
        .max_col      (max_col),
        .max_row      (max_row),
        .local_energy (local_energy),
        .local_count  (local_count),
        .x_centroid   (x_centroid),
        .y_centroid   (y_centroid),
        .phi          (phi),
        .theta        (theta),
        .degenerate   (degenerate)
    );

endmodule

`default_nettype wire

### dv/tb_calorimeter_cluster_centroid.sv
// Self-checking testbench for calorimeter_cluster_centroid: hit streams per event,
// APB register setup between phases, and a bit-exact cluster centroid predictor.
// Depends on ccc_pkg and the calorimeter_cluster_centroid RTL.
`default_nettype none

module tb_calorimeter_cluster_centroid;
    import ccc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam longint ATAN_UNITS [16] = '{
        1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
        7334, 3667, 1833, 917, 458, 229, 115, 57
    };

    typedef struct {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [E_W-1:0]   energy;
        logic             last;
        int               gap;
    } hit_t;

    typedef struct {
        logic [ESUM_W-1:0]  total_energy;
        logic [CNT_W-1:0]   hit_count;
        logic               overflow;
        logic [POS_W-1:0]   max_col;
        logic [POS_W-1:0]   max_row;
        logic [ELOC_W-1:0]  local_energy;
        logic [LCNT_W-1:0]  local_count;
        logic signed [15:0] x_centroid;
        logic signed [15:0] y_centroid;
        logic signed [15:0] phi;
        logic [13:0]        theta;
        logic               degenerate;
    } cluster_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [POS_W-1:0] col = '0;
    logic [POS_W-1:0] row = '0;
    logic [E_W-1:0] energy = '0;
    logic last = 1'b0;
    logic done;
    logic [ESUM_W-1:0] total_energy;
    logic [CNT_W-1:0] hit_count;
    logic overflow;
    logic [POS_W-1:0] max_col;
    logic [POS_W-1:0] max_row;
    logic [ELOC_W-1:0] local_energy;
    logic [LCNT_W-1:0] local_count;
    logic signed [15:0] x_centroid;
    logic signed [15:0] y_centroid;
    logic signed [15:0] phi;
    logic [13:0] theta;
    logic degenerate;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    calorimeter_cluster_centroid u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .col(col), .row(row), .energy(energy), .last(last),
        .done(done), .total_energy(total_energy), .hit_count(hit_count),
        .overflow(overflow), .max_col(max_col), .max_row(max_row),
        .local_energy(local_energy), .local_count(local_count),
        .x_centroid(x_centroid), .y_centroid(y_centroid), .phi(phi),
        .theta(theta), .degenerate(degenerate),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 clk = ~clk;

    hit_t     pending_hits[$];
    cluster_t clusters_due[$];
    int       errors = 0;
    int       idle_cycles = 0;
    int       hits_queued = 0;
    bit       gaps_on = 1'b1;

    // predictor copy of registers and event store
    logic [9:0]       m_pitch_x = 10'd240;
    logic [9:0]       m_pitch_y = 10'd240;
    logic [15:0]      m_front = 16'd7360;
    logic [POS_W-1:0] m_col [MAX_HITS];
    logic [POS_W-1:0] m_row [MAX_HITS];
    logic [E_W-1:0]   m_energy [MAX_HITS];
    int               m_count = 0;
    int               m_peak = 0;
    longint           m_sum = 0;
    bit               m_dropped = 1'b0;

    task automatic report(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
        errors++;
    endtask

    function automatic longint vector_angle(input longint x, input longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int k = 0; k < 16 && y != 0; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0)
            begin
                x += dx; y -= dy; z += ATAN_UNITS[k];
            end
            else
            begin
                x -= dx; y += dy; z -= ATAN_UNITS[k];
            end
        end
        return z;
    endfunction

    function automatic longint full_angle(input longint x, input longint y);
        longint base;
        base = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            base = (y >= 0) ? 180 * 32768 : -180 * 32768;
            x = -x;
            y = -y;
        end
        return base + vector_angle(x, y);
    endfunction

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint round_centroid(input longint num2, input longint e);
        longint unsigned m;
        longint unsigned q;
        m = (num2 < 0) ? longint'(-num2) : longint'(num2);
        q = (m + e) / (2 * e);
        if (q > 32768) q = 32768;
        if (num2 < 0) return -longint'(q);
        return (q > 32767) ? 32767 : longint'(q);
    endfunction

    task automatic absorb_hit(input hit_t h);
        cluster_t c;
        int pc, pr, ci, rj;
        longint eloc, sx2, sy2, xc, yc, ang, th, depth;
        int lcount;
        bit degen;
        if (m_count < MAX_HITS)
        begin
            m_col[m_count] = h.col;
            m_row[m_count] = h.row;
            m_energy[m_count] = h.energy;
            if (m_count == 0 || m_energy[m_peak] < h.energy)
                m_peak = m_count;
            m_count++;
            m_sum = (m_sum + h.energy > 64'h3FFF_FFFF) ? 64'h3FFF_FFFF : m_sum + h.energy;
        end
        else
            m_dropped = 1'b1;
        if (!h.last)
            return;
        pc = m_col[m_peak];
        pr = m_row[m_peak];
        eloc = 0; sx2 = 0; sy2 = 0; lcount = 0;
        xc = 0; yc = 0; ang = 0; th = 0;
        for (int di = -1; di <= 1; di++)
            for (int dj = -1; dj <= 1; dj++)
            begin
                ci = pc + di;
                rj = pr + dj;
                for (int i = 0; i < m_count; i++)
                    if (m_col[i] == ci && m_row[i] == rj)
                    begin
                        eloc += m_energy[i];
                        sx2 += longint'(m_energy[i]) * (m_pitch_x * (2 * ci - GRID_COLS + 1));
                        sy2 += longint'(m_energy[i]) * (m_pitch_y * (2 * rj - GRID_ROWS + 1));
                        lcount++;
                        break;
                    end
            end
        depth = longint'(m_front) - 80;
        degen = (eloc == 0) || (depth <= 0);
        if (!degen)
        begin
            xc = round_centroid(sx2, eloc);
            yc = round_centroid(sy2, eloc);
            ang = (full_angle(xc * 16384, yc * 16384) + 128) >>> 8;
            if (ang > 23040) ang = 23040;
            if (ang < -23040) ang = -23040;
            th = (vector_angle(depth * 16384,
                               int_sqrt(longint'(xc * xc + yc * yc) << 28)) + 128) >>> 8;
            if (th < 0) th = 0;
            if (th > 11520) th = 11520;
        end
        c.total_energy = m_sum[ESUM_W-1:0];
        c.hit_count = CNT_W'(m_count);
        c.overflow = m_dropped;
        c.max_col = POS_W'(pc);
        c.max_row = POS_W'(pr);
        c.local_energy = ELOC_W'(eloc);
        c.local_count = LCNT_W'(lcount);
        c.x_centroid = 16'(xc);
        c.y_centroid = 16'(yc);
        c.phi = 16'(ang);
        c.theta = 14'(th);
        c.degenerate = degen;
        clusters_due.push_back(c);
        m_count = 0; m_peak = 0; m_sum = 0; m_dropped = 1'b0;
    endtask

    // monitor: results first, then the accepted hit
    always @(posedge clk)
    begin
        cluster_t w;
        hit_t h;
        if (rst_n && done)
        begin
            if (clusters_due.size() == 0)
                report("unexpected result", 1, 0);
            else
            begin
                w = clusters_due.pop_front();
                if (total_energy !== w.total_energy) report("total_energy", total_energy, w.total_energy);
                if (hit_count !== w.hit_count) report("hit_count", hit_count, w.hit_count);
                if (overflow !== w.overflow) report("overflow", overflow, w.overflow);
                if (max_col !== w.max_col) report("max_col", max_col, w.max_col);
                if (max_row !== w.max_row) report("max_row", max_row, w.max_row);
                if (local_energy !== w.local_energy) report("local_energy", local_energy, w.local_energy);
                if (local_count !== w.local_count) report("local_count", local_count, w.local_count);
                if (x_centroid !== w.x_centroid) report("x_centroid", x_centroid, w.x_centroid);
                if (y_centroid !== w.y_centroid) report("y_centroid", y_centroid, w.y_centroid);
                if (phi !== w.phi) report("phi", phi, w.phi);
                if (theta !== w.theta) report("theta", theta, w.theta);
                if (degenerate !== w.degenerate) report("degenerate", degenerate, w.degenerate);
            end
        end
        if (rst_n && start && !busy)
        begin
            h.col = col; h.row = row; h.energy = energy; h.last = last; h.gap = 0;
            absorb_hit(h);
        end
    end

    logic taken = 1'b0;
    always @(posedge clk) taken <= rst_n && start && !busy;

    // driver
    hit_t cur;
    bit   waiting = 1'b0;
    int   wait_left = 0;
    always @(negedge clk)
    begin
        if (!rst_n || (start && !taken))
        begin
        end
        else if (waiting)
        begin
            if (wait_left == 0)
            begin
                start <= 1'b1;
                col <= cur.col; row <= cur.row; energy <= cur.energy; last <= cur.last;
                waiting = 1'b0;
            end
            else
            begin
                start <= 1'b0;
                wait_left--;
            end
        end
        else if (pending_hits.size() != 0)
        begin
            cur = pending_hits.pop_front();
            if (cur.gap == 0)
            begin
                start <= 1'b1;
                col <= cur.col; row <= cur.row; energy <= cur.energy; last <= cur.last;
            end
            else
            begin
                start <= 1'b0;
                waiting = 1'b1;
                wait_left = cur.gap - 1;
            end
        end
        else
            start <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_hit(input int c, input int r, input int e, input bit l);
        hit_t h;
        h.col = POS_W'(c); h.row = POS_W'(r); h.energy = E_W'(e); h.last = l;
        h.gap = gaps_on ? $urandom_range(0, 13) : 0;
        pending_hits.push_back(h);
        hits_queued++;
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00}); pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_PITCH_X:    m_pitch_x = v[9:0];
            REG_PITCH_Y:    m_pitch_y = v[9:0];
            REG_FRONT_DIST: m_front = v[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (!(pending_hits.size() == 0 && !waiting && !start && clusters_due.size() == 0))
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic int pick_energy();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 24'hFFFFFF;
            2, 3: return $urandom_range(0, 255);
            4: return 1000;
            default: return $urandom & 24'hFFFFFF;
        endcase
    endfunction

    task automatic random_cluster();
        int n, pc, pr, c, r;
        n = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
        pc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 39);
        pr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 39);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                c = pc + $urandom_range(0, 4) - 2;
                r = pr + $urandom_range(0, 4) - 2;
                c = (c < 0) ? 0 : (c > 63) ? 63 : c;
                r = (r < 0) ? 0 : (r > 63) ? 63 : r;
            end
            else
            begin
                c = $urandom_range(0, 63);
                r = $urandom_range(0, 63);
            end
            add_hit(c, r, pick_energy(), i == n - 1);
        end
    endtask

    initial
    begin
        int px [8];
        int py [8];
        int fd [8];
        px = '{240, 1, 1023, 0, 240, 240, 100, 777};
        py = '{240, 1023, 1, 0, 240, 240, 300, 55};
        fd = '{7360, 65535, 81, 5000, 80, 0, 12345, 300};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single hits at the grid corners and extremes
        add_hit(0, 0, 24'hFFFFFF, 1);
        add_hit(39, 39, 1, 1);
        add_hit(63, 63, 5, 1);
        add_hit(20, 20, 0, 1);
        // equal energies: first stays peak; centroid at the origin
        add_hit(19, 19, 500, 0);
        add_hit(20, 20, 500, 1);
        // negative x on the axis
        add_hit(10, 19, 800, 0);
        add_hit(10, 20, 800, 1);
        // duplicate cells at full energy: first match only
        for (int i = 0; i < 8; i++)
            add_hit(30, 5 + (i % 2), 24'hFFFFFF, i == 7);
        // full store with dropped hits
        for (int i = 0; i < MAX_HITS + 3; i++)
            add_hit(i % 40, 12, i + 1, i == MAX_HITS + 2);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            reg_write(REG_PITCH_X, (p < 6) ? px[p] : $urandom_range(0, 1023));
            reg_write(REG_PITCH_Y, (p < 6) ? py[p] : $urandom_range(0, 1023));
            reg_write(REG_FRONT_DIST, (p < 6) ? fd[p] : $urandom_range(0, 65535));
            gaps_on = (p % 3) != 1;
            while (hits_queued < 100 + (p + 1) * 220)
                random_cluster();
            drain();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hw/rtl/ccc_pkg.sv
hw/rtl/ccc_ram.sv
hw/rtl/ccc_regs.sv
hw/rtl/ccc_datapath.sv
hw/rtl/ccc_ctrl.sv
hw/rtl/calorimeter_cluster_centroid.sv
dv/tb_calorimeter_cluster_centroid.sv
